// ===== rtl/lfs_pkg.sv =====
// Shared types and constants of the line follower steering block.
`default_nettype none

package lfs_pkg;

   // Line side codes, used for line side, moving direction and last seen side.
   typedef enum logic [1:0] {
      SIDE_NONE     = 2'd0,
      SIDE_LEFT     = 2'd1,
      SIDE_RIGHT    = 2'd2,
      SIDE_STRAIGHT = 2'd3
   } side_type;

   // Motor command codes.
   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_APPLY = 2'd2
   } cmd_type;

   localparam int CFG_BITS   = 12;
   localparam int DRIVE_BITS = 7;
   localparam int OUT_BITS   = 8;
   localparam int CSR_IDX_BITS = 3;

   typedef logic [CSR_IDX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_LIFT_THRESHOLD = 3'd0;
   localparam csr_index_type CSR_MIN_CONTRAST   = 3'd1;
   localparam csr_index_type CSR_LIMIT_SEED     = 3'd2;
   localparam csr_index_type CSR_CRUISE_DRIVE   = 3'd3;
   localparam csr_index_type CSR_TURN_DRIVE     = 3'd4;

   localparam logic [CFG_BITS-1:0]   LIFT_RESET     = 12'd250;
   localparam logic [CFG_BITS-1:0]   CONTRAST_RESET = 12'd100;
   localparam logic [CFG_BITS-1:0]   SEED_RESET     = 12'd350;
   localparam logic [DRIVE_BITS-1:0] CRUISE_RESET   = 7'd60;
   localparam logic [DRIVE_BITS-1:0] TURN_RESET     = 7'd100;

   // Per channel control from the steering logic.
   typedef struct packed {
      logic update;     // an item leaves the input stage this cycle
      logic seed_load;  // lifted: reload both limits from the seed
   } chan_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/lfs_stream_if.sv =====
// Item channels of the line follower steering block: sample request and command result.
`default_nettype none

interface lfs_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] left_sample;
   logic [11:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface lfs_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        motor_command;
   logic signed [7:0] left_drive;
   logic signed [7:0] right_drive;
   logic [1:0]        side_seen;

   modport source (output valid, output motor_command, output left_drive,
                   output right_drive, output side_seen, input ready);
   modport sink   (input valid, input motor_command, input left_drive,
                   input right_drive, input side_seen, output ready);
endinterface

`default_nettype wire

// ===== rtl/line_follower_steering.sv =====
// Top level of the line follower steering block: adaptive thresholds and side tracker.
//
// Usage:
//   req_chan carries one left and one right reflectance sample per item.
//   rsp_chan returns one command item per request: motor command (none, stop
//   or apply), left and right drive in signed percent, and the line side.
//   csr_* is a write-only register port: csr_we, csr_index, csr_wdata.
//   Write registers only while no item is in flight.
// Timing:
//   Two stages: an input register, then the steering logic feeding the result
//   register, written as each item leaves the input stage. One item per cycle
//   sustained unless results stall; the limit and side state loop closes within
//   the single steering stage, so back-to-back items see updated state.
// Reset (synchronous, active high):
//   Both stages empty, registers back to their defaults, limits loaded with
//   the default seed, line side, direction and last seen side cleared.
// Backpressure:
//   A stalled result holds in the result register; the input stage holds its
//   item, and req_chan.ready drops only once both stages are full and stalled.
`default_nettype none

module line_follower_steering #(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lfs_req_if.sink                            req_chan,
   lfs_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire lfs_pkg::csr_index_type        csr_index,
   input  wire logic [lfs_pkg::CFG_BITS-1:0]  csr_wdata
);

   localparam int CMP_BITS = (SAMPLE_BITS > lfs_pkg::CFG_BITS) ? SAMPLE_BITS
                                                               : lfs_pkg::CFG_BITS;

   // Configuration registers
   logic [lfs_pkg::CFG_BITS-1:0]   lift_ff, contrast_ff, seed_ff;
   logic [lfs_pkg::DRIVE_BITS-1:0] cruise_ff, turn_ff;

   // Input stage
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] left_ff, right_ff;

   // Steering state
   lfs_pkg::side_type line_side_ff, line_side_in;
   lfs_pkg::side_type direction_ff, direction_in;
   lfs_pkg::side_type last_seen_ff, last_seen_in;

   // Result stage
   logic                             out_valid_ff;
   lfs_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [lfs_pkg::OUT_BITS-1:0]     left_drive_ff, left_drive_in;
   logic [lfs_pkg::OUT_BITS-1:0]     right_drive_ff, right_drive_in;

   logic                   advance, lifted, left_sees, right_sees;
   logic [SAMPLE_BITS-1:0] seed_masked;
   logic [lfs_pkg::OUT_BITS-1:0] turn_pos, turn_neg, cruise_ext;
   lfs_pkg::chan_ctrl_type chan_ctrl;

   // Item moves from input stage to result stage when the result slot is free.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign lifted = (CMP_BITS'(left_ff) < CMP_BITS'(lift_ff))
                   || (CMP_BITS'(right_ff) < CMP_BITS'(lift_ff));

   assign seed_masked = SAMPLE_BITS'(seed_ff);
   assign chan_ctrl   = '{update: advance, seed_load: lifted};

   lfs_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chan_ctrl),
      .sample    (left_ff),
      .seed      (seed_masked),
      .contrast  (contrast_ff),
      .sees_line (left_sees)
   );

   lfs_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chan_ctrl),
      .sample    (right_ff),
      .seed      (seed_masked),
      .contrast  (contrast_ff),
      .sees_line (right_sees)
   );

   // Drive values; turn drive negated in 8 bits.
   assign turn_pos   = lfs_pkg::OUT_BITS'(turn_ff);
   assign turn_neg   = lfs_pkg::OUT_BITS'(8'd0 - turn_pos);
   assign cruise_ext = lfs_pkg::OUT_BITS'(cruise_ff);

   // Side tracker and command select
   always_comb begin
      line_side_in   = line_side_ff;
      direction_in   = direction_ff;
      last_seen_in   = last_seen_ff;
      cmd_in         = lfs_pkg::CMD_NONE;
      left_drive_in  = '0;
      right_drive_in = '0;

      if (lifted) begin
         // Robot lifted: stop, forget the line, keep last seen side
         line_side_in = lfs_pkg::SIDE_NONE;
         direction_in = lfs_pkg::SIDE_NONE;
         cmd_in       = lfs_pkg::CMD_STOP;
      end else begin
         if (left_sees && right_sees)
            line_side_in = lfs_pkg::SIDE_STRAIGHT;
         else if (left_sees)
            line_side_in = lfs_pkg::SIDE_LEFT;
         else if (right_sees)
            line_side_in = lfs_pkg::SIDE_RIGHT;
         else if ((line_side_ff == lfs_pkg::SIDE_RIGHT) && (direction_ff == lfs_pkg::SIDE_RIGHT))
            line_side_in = lfs_pkg::SIDE_STRAIGHT;
         else if ((line_side_ff == lfs_pkg::SIDE_LEFT) && (direction_ff == lfs_pkg::SIDE_LEFT))
            line_side_in = lfs_pkg::SIDE_STRAIGHT;
         else
            line_side_in = lfs_pkg::SIDE_NONE;

         // Remember where the line was when it was last in view
         if (line_side_ff != lfs_pkg::SIDE_NONE) begin
            if (line_side_in == lfs_pkg::SIDE_NONE)
               last_seen_in = line_side_ff;
            else
               last_seen_in = line_side_in;
         end

         if (line_side_in == lfs_pkg::SIDE_NONE) begin
            // Line lost: pivot back toward the last seen side
            if (last_seen_in == lfs_pkg::SIDE_RIGHT) begin
               direction_in   = lfs_pkg::SIDE_RIGHT;
               cmd_in         = lfs_pkg::CMD_APPLY;
               left_drive_in  = turn_pos;
               right_drive_in = turn_neg;
            end else if (last_seen_in == lfs_pkg::SIDE_LEFT) begin
               direction_in   = lfs_pkg::SIDE_LEFT;
               cmd_in         = lfs_pkg::CMD_APPLY;
               left_drive_in  = turn_neg;
               right_drive_in = turn_pos;
            end
         end else begin
            direction_in   = lfs_pkg::SIDE_STRAIGHT;
            cmd_in         = lfs_pkg::CMD_APPLY;
            left_drive_in  = cruise_ext;
            right_drive_in = cruise_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff      <= lfs_pkg::LIFT_RESET;
         contrast_ff  <= lfs_pkg::CONTRAST_RESET;
         seed_ff      <= lfs_pkg::SEED_RESET;
         cruise_ff    <= lfs_pkg::CRUISE_RESET;
         turn_ff      <= lfs_pkg::TURN_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         line_side_ff <= lfs_pkg::SIDE_NONE;
         direction_ff <= lfs_pkg::SIDE_NONE;
         last_seen_ff <= lfs_pkg::SIDE_NONE;
         cmd_ff       <= lfs_pkg::CMD_NONE;
      end else begin
         if (csr_we) begin
            case (csr_index)
               lfs_pkg::CSR_LIFT_THRESHOLD: lift_ff     <= csr_wdata;
               lfs_pkg::CSR_MIN_CONTRAST:   contrast_ff <= csr_wdata;
               lfs_pkg::CSR_LIMIT_SEED:     seed_ff     <= csr_wdata;
               lfs_pkg::CSR_CRUISE_DRIVE:   cruise_ff   <= csr_wdata[lfs_pkg::DRIVE_BITS-1:0];
               lfs_pkg::CSR_TURN_DRIVE:     turn_ff     <= csr_wdata[lfs_pkg::DRIVE_BITS-1:0];
               default: ;
            endcase
         end

         if (req_chan.ready)
            in_valid_ff <= req_chan.valid;

         if (advance) begin
            out_valid_ff <= 1'b1;
            line_side_ff <= line_side_in;
            direction_ff <= direction_in;
            last_seen_ff <= last_seen_in;
            cmd_ff       <= cmd_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         left_ff  <= SAMPLE_BITS'(req_chan.left_sample);
         right_ff <= SAMPLE_BITS'(req_chan.right_sample);
      end
      if (advance) begin
         left_drive_ff  <= left_drive_in;
         right_drive_ff <= right_drive_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.motor_command = cmd_ff;
   assign rsp_chan.left_drive    = left_drive_ff;
   assign rsp_chan.right_drive   = right_drive_ff;
   assign rsp_chan.side_seen     = line_side_ff;

endmodule

`default_nettype wire

// ===== rtl/lfs_channel.sv =====
// Adaptive min/max limit tracker and line detector for one reflectance channel.
`default_nettype none

module lfs_channel #(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lfs_pkg::chan_ctrl_type         ctrl,
   input  wire logic [SAMPLE_BITS-1:0]         sample,
   input  wire logic [SAMPLE_BITS-1:0]         seed,
   input  wire logic [lfs_pkg::CFG_BITS-1:0]   contrast,
   output logic                                sees_line
);

   localparam int CMP_BITS = (SAMPLE_BITS > lfs_pkg::CFG_BITS) ? SAMPLE_BITS
                                                               : lfs_pkg::CFG_BITS;

   logic [SAMPLE_BITS-1:0] low_ff, low_in;
   logic [SAMPLE_BITS-1:0] high_ff, high_in;
   logic [SAMPLE_BITS-1:0] wide_low, wide_high, span;
   logic [SAMPLE_BITS:0]   sum;
   logic [SAMPLE_BITS-1:0] mid;

   // Widen the limits to include the sample, then test against the new span.
   always_comb begin
      wide_low  = (sample < low_ff)  ? sample : low_ff;
      wide_high = (sample > high_ff) ? sample : high_ff;
      span      = wide_high - wide_low;
      sum       = {1'b0, wide_high} + {1'b0, wide_low};
      mid       = sum[SAMPLE_BITS:1];
      sees_line = (wide_high >= wide_low)
                  && (CMP_BITS'(span) >= CMP_BITS'(contrast))
                  && (sample < mid);
      low_in    = ctrl.seed_load ? seed : wide_low;
      high_in   = ctrl.seed_load ? seed : wide_high;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= SAMPLE_BITS'(lfs_pkg::SEED_RESET);
         high_ff <= SAMPLE_BITS'(lfs_pkg::SEED_RESET);
      end else if (ctrl.update) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

endmodule

`default_nettype wire
